/* hdl/channel_frame_deframer_macros.svh */
// Assertion macros for the channel frame deframer.
// Each expects clk and rst_n in scope.
`ifndef CHANNEL_FRAME_DEFRAMER_MACROS_SVH
`define CHANNEL_FRAME_DEFRAMER_MACROS_SVH

`define CFD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");

`define CFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

`define CFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* hdl/cfd_pkg.sv */
`default_nettype none
package cfd_pkg;

  localparam logic [7:0] DELIM_BYTE = 8'h7E;
  localparam logic [3:0] NIBBLE_MASK = 4'h0F;
  localparam int unsigned RQ_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_WAIT_START = 3'd1,
    MODE_CHAN_LENH  = 3'd2,
    MODE_LEN_LOW    = 3'd3,
    MODE_PAYLOAD    = 3'd4,
    MODE_CLOSE      = 3'd5,
    MODE_PARTIAL    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_BYTE      = 3'd0,
    ST_DONE      = 3'd1,
    ST_PARTIAL   = 3'd2,
    ST_BAD_CHAN  = 3'd3,
    ST_FRAMING   = 3'd4,
    ST_NOT_ARMED = 3'd5
  } status_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_ARM  = 1'b1
  } kind_t;

  typedef enum logic {
    REG_CHANNEL_ENABLE_MASK = 1'b0,
    REG_BUFFER_CAPACITY     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  channel;
    logic [7:0]  data_byte;
    logic [11:0] byte_index;
    logic [11:0] length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

/* hdl/cfd_cfg.sv */
`default_nettype none
module cfd_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [7:0]       chan_mask,
  output logic [11:0]      buf_cap
);
  import cfd_pkg::*;

  logic [7:0]  mask_r;
  logic [11:0] cap_r;
  logic        wr;
  reg_idx_t    idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 8'd0;
      cap_r  <= 12'd4095;
    end else if (wr) begin
      case (idx)
        REG_CHANNEL_ENABLE_MASK: mask_r <= pwdata[7:0];
        REG_BUFFER_CAPACITY:     cap_r  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHANNEL_ENABLE_MASK: prdata = {24'd0, mask_r};
      REG_BUFFER_CAPACITY:     prdata = {20'd0, cap_r};
      default:                 prdata = 32'd0;
    endcase
  end

  assign chan_mask = mask_r;
  assign buf_cap   = cap_r;
endmodule
`default_nettype wire

/* hdl/cfd_core.sv */
`default_nettype none
module cfd_core #(
  parameter int CHANNEL_COUNT = 8,
  parameter int MAX_FRAME_LEN = 4095
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        kind,
  input  wire logic [7:0]  line_byte,
  input  wire logic [7:0]  chan_mask,
  input  wire logic [11:0] buf_cap,
  output cfd_pkg::push_t   push
);
  import cfd_pkg::*;

  localparam logic [4:0]  CH_LIM  = 5'(CHANNEL_COUNT);
  localparam logic [11:0] LEN_LIM = 12'(MAX_FRAME_LEN);

  mode_t       mode_r, mode_nxt;
  logic [3:0]  chan_r, chan_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [11:0] fill_r, fill_nxt;
  logic [11:0] fill_inc;
  logic [11:0] rem_low;
  logic [3:0]  hi_nib;
  logic        chan_ok;
  push_t       p;

  assign hi_nib   = line_byte[7:4];
  assign chan_ok  = ({1'b0, hi_nib} < CH_LIM) && !hi_nib[3] && chan_mask[hi_nib[2:0]];
  assign fill_inc = fill_r + 12'd1;
  assign rem_low  = rem_r | {4'd0, line_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      chan_r <= 4'd0;
      rem_r  <= 12'd0;
      fill_r <= 12'd0;
    end else begin
      mode_r <= mode_nxt;
      chan_r <= chan_nxt;
      rem_r  <= rem_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    chan_nxt = chan_r;
    rem_nxt  = rem_r;
    fill_nxt = fill_r;
    p        = '0;
    p.r0.status = ST_BYTE;
    p.r1.status = ST_BYTE;
    if (accept) begin
      if (kind_t'(kind) == KIND_ARM) begin
        if (buf_cap <= LEN_LIM) begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt = MODE_WAIT_START;
          end else if (mode_r == MODE_PARTIAL) begin
            fill_nxt = 12'd0;
            mode_nxt = MODE_PAYLOAD;
          end
        end
      end else begin
        case (mode_r)
          MODE_WAIT_START: begin
            if (line_byte == DELIM_BYTE) mode_nxt = MODE_CHAN_LENH;
          end
          MODE_CHAN_LENH: begin
            if (line_byte != DELIM_BYTE) begin
              chan_nxt = hi_nib;
              rem_nxt  = {line_byte[3:0] & NIBBLE_MASK, 8'd0};
              if (!chan_ok) begin
                mode_nxt       = MODE_IDLE;
                p.count        = 2'd1;
                p.r0.status    = ST_BAD_CHAN;
                p.r0.last      = 1'b1;
              end else begin
                mode_nxt = MODE_LEN_LOW;
              end
            end
          end
          MODE_LEN_LOW: begin
            rem_nxt  = rem_low;
            fill_nxt = 12'd0;
            mode_nxt = (rem_low != 12'd0) ? MODE_PAYLOAD : MODE_CLOSE;
          end
          MODE_PAYLOAD: begin
            p.count         = 2'd1;
            p.r0.status     = ST_BYTE;
            p.r0.channel    = chan_r;
            p.r0.data_byte  = line_byte;
            p.r0.byte_index = fill_r;
            p.r0.last       = 1'b1;
            fill_nxt        = fill_inc;
            if (fill_inc >= rem_r) begin
              mode_nxt = MODE_CLOSE;
            end else if (fill_inc >= buf_cap) begin
              rem_nxt      = rem_r - fill_inc;
              mode_nxt     = MODE_PARTIAL;
              p.count      = 2'd2;
              p.r0.last    = 1'b0;
              p.r1.status  = ST_PARTIAL;
              p.r1.channel = chan_r;
              p.r1.length  = fill_inc;
              p.r1.last    = 1'b1;
            end
          end
          MODE_CLOSE: begin
            mode_nxt  = MODE_IDLE;
            p.count   = 2'd1;
            p.r0.last = 1'b1;
            if (line_byte == DELIM_BYTE) begin
              p.r0.status  = ST_DONE;
              p.r0.channel = chan_r;
              p.r0.length  = fill_r;
            end else begin
              p.r0.status = ST_FRAMING;
            end
          end
          default: begin
            mode_nxt    = MODE_IDLE;
            p.count     = 2'd1;
            p.r0.status = ST_NOT_ARMED;
            p.r0.last   = 1'b1;
          end
        endcase
      end
    end
  end

  assign push = p;
endmodule
`default_nettype wire

/* hdl/cfd_rq.sv */
`default_nettype none
module cfd_rq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cfd_pkg::push_t push,
  output logic                full2,
  output logic                valid,
  input  wire logic           pop,
  output cfd_pkg::result_t    head
);
  import cfd_pkg::*;

  localparam int AW = $clog2(RQ_DEPTH);
  localparam int CW = $clog2(RQ_DEPTH + 1);

  result_t         mem_r [RQ_DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign valid  = cnt_r != '0;
  assign do_pop = pop & valid;
  assign full2  = cnt_r > CW'(RQ_DEPTH - 2);
  assign head   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + AW'(push.count);
    rp_nxt  = rp_r + AW'(do_pop);
    cnt_nxt = cnt_r + CW'(push.count) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wp_r] <= push.r0;
    if (push.count == 2'd2) mem_r[wp_r + AW'(1)] <= push.r1;
  end
endmodule
`default_nettype wire

/* hdl/channel_frame_deframer.sv */
`default_nettype none
// Channel frame deframer: takes one transaction per clock on in_ (a line byte or an
// arm command) and emits payload bytes with buffer index, frame/partial completions
// and error reports on out_, up to two results per transaction. Results are
// registered in a four-entry result queue that decouples the sides, and in_stall
// rises while fewer than two queue entries are free, so the sustained rate is one
// transaction per cycle unless out_ is stalled or partial completions (two
// results per transaction) arrive faster than out_ drains.
// Registers: 0x0 channel enable mask (8 bits), 0x4 buffer capacity (12 bits).
module channel_frame_deframer #(
  parameter int CHANNEL_COUNT = 8,
  parameter int MAX_FRAME_LEN = 4095
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_line_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [3:0]       out_channel,
  output logic [7:0]       out_data_byte,
  output logic [11:0]      out_byte_index,
  output logic [11:0]      out_length,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cfd_pkg::*;

  logic [7:0]  chan_mask;
  logic [11:0] buf_cap;
  logic        accept;
  logic        full2;
  push_t       push;
  result_t     head;

  assign in_stall = full2;
  assign accept   = in_valid & ~full2;

  cfd_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .chan_mask, .buf_cap
  );

  cfd_core #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_core (
    .clk, .rst_n, .accept, .kind(in_kind), .line_byte(in_line_byte),
    .chan_mask, .buf_cap, .push
  );

  cfd_rq u_rq (
    .clk, .rst_n, .push, .full2, .valid(out_valid), .pop(~out_stall), .head
  );

  assign out_status     = head.status;
  assign out_channel    = head.channel;
  assign out_data_byte  = head.data_byte;
  assign out_byte_index = head.byte_index;
  assign out_length     = head.length;
  assign out_last       = head.last;
endmodule
`default_nettype wire

/* hdl/cfd_checker.sv */
`default_nettype none
`include "channel_frame_deframer_macros.svh"
module cfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [3:0]  out_channel,
  input wire logic [11:0] out_length,
  input wire logic        out_last,
  input wire logic        pready
);
  import cfd_pkg::*;

  `CFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status))
  `CFD_ASSERT_ALWAYS(a_pready, pready)
  `CFD_ASSERT_IMPL(a_partial_last, out_valid && out_status == ST_PARTIAL, out_last)
  `CFD_ASSERT_IMPL(a_err_clean,
    out_valid && (out_status == ST_BAD_CHAN || out_status == ST_FRAMING ||
    out_status == ST_NOT_ARMED), out_last && out_channel == 4'd0 && out_length == 12'd0)
endmodule

bind channel_frame_deframer cfd_checker u_cfd_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_status, .out_channel, .out_length,
  .out_last, .pready
);
`default_nettype wire
